### rtl/core/pixel_blend_modes_defines.svh
// ---------------------------------------------------------------------------
// pixel blend modes assertion macros
// ---------------------------------------------------------------------------
`ifndef PIXEL_BLEND_MODES_DEFINES_SVH
`define PIXEL_BLEND_MODES_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PBM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pbm_pkg.sv
// ---------------------------------------------------------------------------
// pbm_pkg
// shared types, codes and constants of the pixel blend block
// ---------------------------------------------------------------------------
package pbm_pkg;

  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned OP_W      = 9;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  localparam logic [OP_W-1:0]   OP_FULL       = 9'd256;
  localparam logic [OP_W-1:0]   OP_RESET      = 9'd256;
  localparam logic [CH_W-1:0]   CH_MAX        = 8'd255;
  localparam logic [CH_W-1:0]   CH_HALF       = 8'd127;

  // register index, taken from paddr[2]
  localparam logic REG_BLEND_MODE = 1'b0;
  localparam logic REG_OPACITY    = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL     = 3'd0,
    MODE_MULTIPLY   = 3'd1,
    MODE_SCREEN     = 3'd2,
    MODE_OVERLAY    = 3'd3,
    MODE_DIFFERENCE = 3'd4
  } blend_mode_t;

  typedef struct packed {
    logic [CH_W-1:0] base_red;
    logic [CH_W-1:0] base_green;
    logic [CH_W-1:0] base_blue;
    logic [CH_W-1:0] layer_red;
    logic [CH_W-1:0] layer_green;
    logic [CH_W-1:0] layer_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } pixel_out_t;

  // settings shared by all lanes
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [OP_W-1:0]   op;
  } pbm_ctrl_t;

endpackage

### rtl/core/pbm_lane.sv
// ---------------------------------------------------------------------------
// pbm_lane
// one color channel: blend value by mode, round divide by 255, opacity mix
// ---------------------------------------------------------------------------
module pbm_lane (
  input  logic                         clk,
  input  pbm_pkg::pbm_ctrl_t           ctrl,
  input  logic [pbm_pkg::CH_W-1:0]     base_ch,
  input  logic [pbm_pkg::CH_W-1:0]     layer_ch,
  output logic [pbm_pkg::CH_W-1:0]     mix_ch
);

  // stage 1: operand select and product
  logic [7:0]  inv_a, inv_b;
  logic [7:0]  mul_a, mul_b;
  logic        dbl, inv, use_div;
  logic [7:0]  direct;
  logic [15:0] prod;
  logic [16:0] prod_x;

  logic [16:0] x_r;
  logic        inv_r, use_div_r;
  logic [7:0]  direct_r, a1_r;

  always_comb begin
    inv_a   = pbm_pkg::CH_MAX - base_ch;
    inv_b   = pbm_pkg::CH_MAX - layer_ch;
    mul_a   = base_ch;
    mul_b   = layer_ch;
    dbl     = 1'b0;
    inv     = 1'b0;
    use_div = 1'b0;
    direct  = base_ch;
    case (pbm_pkg::blend_mode_t'(ctrl.mode))
      pbm_pkg::MODE_NORMAL: begin
        direct = layer_ch;
      end
      pbm_pkg::MODE_MULTIPLY: begin
        use_div = 1'b1;
      end
      pbm_pkg::MODE_SCREEN: begin
        mul_a   = inv_a;
        mul_b   = inv_b;
        inv     = 1'b1;
        use_div = 1'b1;
      end
      pbm_pkg::MODE_OVERLAY: begin
        dbl     = 1'b1;
        use_div = 1'b1;
        if (base_ch > pbm_pkg::CH_HALF) begin
          mul_a = inv_a;
          mul_b = inv_b;
          inv   = 1'b1;
        end
      end
      pbm_pkg::MODE_DIFFERENCE: begin
        direct = (base_ch >= layer_ch) ? (base_ch - layer_ch) : (layer_ch - base_ch);
      end
      default: begin
        direct = base_ch;
      end
    endcase
    prod   = 16'(mul_a) * 16'(mul_b);
    prod_x = dbl ? {prod, 1'b0} : {1'b0, prod};
  end

  always_ff @(posedge clk) begin
    x_r       <= prod_x;
    inv_r     <= inv;
    use_div_r <= use_div;
    direct_r  <= direct;
    a1_r      <= base_ch;
  end

  // stage 2: round(x/255) as y>>8 plus up to two corrections
  logic [17:0] y;
  logic [9:0]  q0;
  logic [10:0] rem;
  logic [9:0]  q;
  logic [7:0]  q8, bl;
  logic [7:0]  bl_r, a2_r;

  always_comb begin
    y   = {1'b0, x_r} + 18'd127;
    q0  = y[17:8];
    rem = {3'b000, y[7:0]} + {1'b0, q0};
    q   = q0 + {9'd0, (rem >= 11'd255)} + {9'd0, (rem >= 11'd510)};
    q8  = q[7:0];
    if (!use_div_r) begin
      bl = direct_r;
    end else if (inv_r) begin
      bl = pbm_pkg::CH_MAX - q8;
    end else begin
      bl = q8;
    end
  end

  always_ff @(posedge clk) begin
    bl_r <= bl;
    a2_r <= a1_r;
  end

  // stage 3: a + op*(bl-a)/256, rounded
  logic signed [9:0]  diff;
  logic signed [9:0]  op_s;
  logic signed [19:0] wprod;
  logic signed [19:0] acc;
  logic [7:0]         mix;
  logic [7:0]         mix_r;

  always_comb begin
    diff  = $signed({2'b00, bl_r}) - $signed({2'b00, a2_r});
    op_s  = $signed({1'b0, ctrl.op});
    wprod = 20'(diff * op_s);
    acc   = $signed({4'b0000, a2_r, 8'd0}) + wprod + 20'sd128;
    if (acc[19]) begin
      mix = 8'd0;
    end else if (acc[18:16] != 3'b000) begin
      mix = pbm_pkg::CH_MAX;
    end else begin
      mix = acc[15:8];
    end
  end

  always_ff @(posedge clk) begin
    mix_r <= mix;
  end

  assign mix_ch = mix_r;

endmodule

### rtl/core/pbm_merge.sv
// ---------------------------------------------------------------------------
// pbm_merge
// gathers the lane results into one pixel and drives the result strobe
// ---------------------------------------------------------------------------
module pbm_merge (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       lane_valid,
  input  logic [pbm_pkg::NUM_LANES-1:0][pbm_pkg::CH_W-1:0] lane_ch,
  output logic                                       out_valid,
  output pbm_pkg::pixel_out_t                        out_pixel
);

  logic                out_valid_r;
  pbm_pkg::pixel_out_t out_pixel_r, out_pixel_nxt;

  always_comb begin
    out_pixel_nxt.out_red   = lane_ch[0];
    out_pixel_nxt.out_green = lane_ch[1];
    out_pixel_nxt.out_blue  = lane_ch[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

endmodule

### rtl/core/pixel_blend_modes.sv
// ---------------------------------------------------------------------------
// pixel_blend_modes
// per-channel layer blending (normal, multiply, screen, overlay, difference)
// with opacity mix, three channel lanes in parallel
// ---------------------------------------------------------------------------
// accepted requests pass the lane stages and the merge register to out_valid
// throughput: one pixel per cycle, set by the three-stage lane pipeline
// busy is high in reset and the cycle after; low from then on
// results are strobed for one cycle; the receiver cannot stall
// synchronous active-low reset clears the valid pipeline and the registers
// (blend_mode 0, opacity_level 256)
module pixel_blend_modes (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pbm_pkg::pixel_in_t            in_pixel,
  output logic                          out_valid,
  output pbm_pkg::pixel_out_t           out_pixel,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbm_pkg::ADDR_W-1:0]    paddr,
  input  logic [pbm_pkg::DATA_W-1:0]    pwdata,
  output logic [pbm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [pbm_pkg::MODE_W-1:0] cfg_mode_r;
  logic [pbm_pkg::OP_W-1:0]   cfg_opacity_r;
  logic                       cfg_wr;
  logic                       busy_r;
  logic                       accept;
  logic [2:0]                 vld_r;
  pbm_pkg::pbm_ctrl_t         ctrl;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r    <= pbm_pkg::MODE_NORMAL;
      cfg_opacity_r <= pbm_pkg::OP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        pbm_pkg::REG_BLEND_MODE: cfg_mode_r    <= pwdata[pbm_pkg::MODE_W-1:0];
        pbm_pkg::REG_OPACITY:    cfg_opacity_r <= pwdata[pbm_pkg::OP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pbm_pkg::REG_BLEND_MODE: prdata = {29'd0, cfg_mode_r};
      pbm_pkg::REG_OPACITY:    prdata = {23'd0, cfg_opacity_r};
      default:                 prdata = '0;
    endcase
  end

  // opacity above full saturates to full
  always_comb begin
    ctrl.mode = cfg_mode_r;
    ctrl.op   = (cfg_opacity_r > pbm_pkg::OP_FULL) ? pbm_pkg::OP_FULL : cfg_opacity_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[1:0], accept};
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  logic [pbm_pkg::NUM_LANES-1:0][pbm_pkg::CH_W-1:0] base_ch, layer_ch, lane_ch;

  always_comb begin
    base_ch[0]  = in_pixel.base_red;
    base_ch[1]  = in_pixel.base_green;
    base_ch[2]  = in_pixel.base_blue;
    layer_ch[0] = in_pixel.layer_red;
    layer_ch[1] = in_pixel.layer_green;
    layer_ch[2] = in_pixel.layer_blue;
  end

  for (genvar g = 0; g < pbm_pkg::NUM_LANES; g++) begin : g_lane
    pbm_lane u_lane (
      .clk      (clk),
      .ctrl     (ctrl),
      .base_ch  (base_ch[g]),
      .layer_ch (layer_ch[g]),
      .mix_ch   (lane_ch[g])
    );
  end

  pbm_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (vld_r[2]),
    .lane_ch    (lane_ch),
    .out_valid  (out_valid),
    .out_pixel  (out_pixel)
  );

endmodule

### rtl/core/pbm_checker.sv
// ---------------------------------------------------------------------------
// pbm_checker
// port-level timing and register checks for the pixel blend block
// ---------------------------------------------------------------------------
`include "pixel_blend_modes_defines.svh"

module pbm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [pbm_pkg::ADDR_W-1:0]    paddr,
  input logic [pbm_pkg::DATA_W-1:0]    pwdata,
  input logic [pbm_pkg::DATA_W-1:0]    prdata
);

  logic mode_wr;
  logic mode_rd;

  assign mode_wr = psel && penable && pwrite && (paddr[2] == pbm_pkg::REG_BLEND_MODE);
  assign mode_rd = psel && !pwrite && (paddr[2] == pbm_pkg::REG_BLEND_MODE);

  // every accepted request comes out as an out_valid strobe
  `PBM_ASSERT_SAME(a_req_to_result, clk, rst_n, start && !busy, ##4 out_valid, "request lost")

  // no result without an earlier accepted request
  `PBM_ASSERT_SAME(a_result_has_req, clk, rst_n, out_valid, $past(start && !busy, 4), "spurious result")

  // blend mode reads back what was written
  `PBM_ASSERT_NEXT(a_mode_readback, clk, rst_n, mode_wr, !mode_rd || (prdata[2:0] == $past(pwdata[2:0])), "mode readback mismatch")

endmodule

bind pixel_blend_modes pbm_checker u_pbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pixel_blend_modes testbench
// directed table of pixels and register writes, then random pixel streams
// under changing blend mode, opacity and request gaps, each checked against
// its table value or a behavioral blend calculation in strict arrival order
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned LATENCY        = 4;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned RANDOM_PHASES  = 12;
  localparam int unsigned PHASE_PIXELS   = 100;
  // mode codes with no blend formula: the base channel passes through
  localparam logic [pbm_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [pbm_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic                       reg_sel;
    logic [pbm_pkg::DATA_W-1:0] value;
    pbm_pkg::pixel_in_t         pix;
    bit                         typed;
    pbm_pkg::pixel_out_t        want;
  } script_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  pbm_pkg::pixel_in_t         in_pixel = '0;
  logic                       out_valid;
  pbm_pkg::pixel_out_t        out_pixel;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [pbm_pkg::ADDR_W-1:0] paddr = '0;
  logic [pbm_pkg::DATA_W-1:0] pwdata = '0;
  logic [pbm_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  logic [pbm_pkg::MODE_W-1:0] cur_mode = pbm_pkg::MODE_NORMAL;
  logic [pbm_pkg::OP_W-1:0]   cur_op = pbm_pkg::OP_RESET;
  pbm_pkg::pixel_out_t        expected_pixels [$];
  script_row_t                script [$];
  int unsigned                mismatches = 0;
  int unsigned                pixels_sent = 0;
  int unsigned                pixels_seen = 0;
  int unsigned                settings_used = 0;
  int unsigned                cycle_count = 0;

  pixel_blend_modes dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_pixel (out_pixel),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_pixels.size());
      $display("FAILURE");
      $finish;
    end
  end

  // round(x / 255), exact since 255 is odd
  function automatic int unsigned div255_round(input int unsigned x);
    return (x + 127) / 255;
  endfunction

  function automatic logic [pbm_pkg::CH_W-1:0] blend_lane(
      input logic [pbm_pkg::CH_W-1:0] a, b);
    int unsigned ai, bi, bl, op, mix;
    ai = a;
    bi = b;
    op = (cur_op > pbm_pkg::OP_FULL) ? pbm_pkg::OP_FULL : cur_op;
    case (cur_mode)
      pbm_pkg::MODE_NORMAL:     bl = bi;
      pbm_pkg::MODE_MULTIPLY:   bl = div255_round(ai * bi);
      pbm_pkg::MODE_SCREEN:     bl = 255 - div255_round((255 - ai) * (255 - bi));
      pbm_pkg::MODE_OVERLAY:    bl = (ai <= pbm_pkg::CH_HALF) ? div255_round(2 * ai * bi)
                                     : 255 - div255_round(2 * (255 - ai) * (255 - bi));
      pbm_pkg::MODE_DIFFERENCE: bl = (ai >= bi) ? ai - bi : bi - ai;
      default:                  bl = ai;
    endcase
    mix = (op * bl + (256 - op) * ai + 128) >> 8;
    return (mix > pbm_pkg::CH_MAX) ? pbm_pkg::CH_MAX : mix[pbm_pkg::CH_W-1:0];
  endfunction

  function automatic pbm_pkg::pixel_out_t blend_pixel(input pbm_pkg::pixel_in_t p);
    pbm_pkg::pixel_out_t r;
    r.out_red   = blend_lane(p.base_red, p.layer_red);
    r.out_green = blend_lane(p.base_green, p.layer_green);
    r.out_blue  = blend_lane(p.base_blue, p.layer_blue);
    return r;
  endfunction

  // corner values show up often, the rest is uniform
  function automatic logic [pbm_pkg::CH_W-1:0] pick_channel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return pbm_pkg::CH_MAX;
      2:       return pbm_pkg::CH_HALF;
      3:       return pbm_pkg::CH_HALF + 8'd1;
      default: return pbm_pkg::CH_W'($urandom_range(255));
    endcase
  endfunction

  function automatic pbm_pkg::pixel_in_t pick_pixel();
    pbm_pkg::pixel_in_t p;
    p.base_red    = pick_channel();
    p.base_green  = pick_channel();
    p.base_blue   = pick_channel();
    p.layer_red   = pick_channel();
    p.layer_green = pick_channel();
    p.layer_blue  = pick_channel();
    return p;
  endfunction

  task automatic add_cfg(input logic reg_sel, input int unsigned value);
    script_row_t r;
    r = '{ROW_CFG, reg_sel, pbm_pkg::DATA_W'(value), '0, 1'b0, '0};
    script.push_back(r);
  endtask

  task automatic add_pixel(input pbm_pkg::pixel_in_t p, input bit typed,
                           input pbm_pkg::pixel_out_t want);
    script_row_t r;
    r = '{ROW_PIXEL, 1'b0, '0, p, typed, want};
    script.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [pbm_pkg::CH_W-1:0] want, got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
    end
  endtask

  // results cannot be held off, so every strobe is taken at once
  always @(posedge clk) begin
    pbm_pkg::pixel_out_t want;
    if (rst_n && out_valid) begin
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, got %06h", $time, out_pixel);
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_red", want.out_red, out_pixel.out_red);
        check_field("out_green", want.out_green, out_pixel.out_green);
        check_field("out_blue", want.out_blue, out_pixel.out_blue);
      end
    end
  end

  task automatic send_pixel(input pbm_pkg::pixel_in_t p, input bit typed,
                            input pbm_pkg::pixel_out_t want, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (busy);
    expected_pixels.push_back(typed ? want : blend_pixel(p));
    pixels_sent++;
  endtask

  // registers change only with the pipeline empty
  task automatic write_reg(input logic reg_sel, input logic [pbm_pkg::DATA_W-1:0] value);
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == pbm_pkg::REG_BLEND_MODE)
      cur_mode = value[pbm_pkg::MODE_W-1:0];
    else
      cur_op = value[pbm_pkg::OP_W-1:0];
    settings_used++;
  endtask

  initial begin
    int unsigned op_corner [7];
    int unsigned idle_pct [3];
    int unsigned op_val;

    op_corner = '{0, 256, 1, 255, 128, 257, 511};
    idle_pct  = '{0, 81, 11};

    // reset values: normal mode at full opacity passes the layer through
    add_pixel(pbm_pkg::pixel_in_t'(48'h000000_ff8001), 1'b1,
              pbm_pkg::pixel_out_t'(24'hff8001));
    add_pixel(pbm_pkg::pixel_in_t'(48'hffffff_000000), 1'b1,
              pbm_pkg::pixel_out_t'(24'h000000));
    add_cfg(pbm_pkg::REG_BLEND_MODE, pbm_pkg::MODE_MULTIPLY);
    add_pixel(pbm_pkg::pixel_in_t'(48'hffffff_ff0080), 1'b1,
              pbm_pkg::pixel_out_t'(24'hff0080));
    add_cfg(pbm_pkg::REG_BLEND_MODE, pbm_pkg::MODE_SCREEN);
    add_pixel(pbm_pkg::pixel_in_t'(48'h000000_00ff40), 1'b1,
              pbm_pkg::pixel_out_t'(24'h00ff40));
    // overlay switches formula between 127 and 128
    add_cfg(pbm_pkg::REG_BLEND_MODE, pbm_pkg::MODE_OVERLAY);
    add_pixel(pbm_pkg::pixel_in_t'(48'h7f8000_ffffff), 1'b1,
              pbm_pkg::pixel_out_t'(24'hfeff00));
    add_pixel(pbm_pkg::pixel_in_t'(48'h7f80ff_000000), 1'b1,
              pbm_pkg::pixel_out_t'(24'h0001ff));
    add_cfg(pbm_pkg::REG_BLEND_MODE, pbm_pkg::MODE_DIFFERENCE);
    add_pixel(pbm_pkg::pixel_in_t'(48'hff0080_00ff80), 1'b1,
              pbm_pkg::pixel_out_t'(24'hffff00));
    add_cfg(pbm_pkg::REG_BLEND_MODE, MODE_SPARE_LO);
    add_pixel(pbm_pkg::pixel_in_t'(48'h123456_abcdef), 1'b1,
              pbm_pkg::pixel_out_t'(24'h123456));
    add_cfg(pbm_pkg::REG_BLEND_MODE, MODE_SPARE_HI);
    add_pixel(pbm_pkg::pixel_in_t'(48'hfedcba_012345), 1'b1,
              pbm_pkg::pixel_out_t'(24'hfedcba));
    // zero opacity keeps the base
    add_cfg(pbm_pkg::REG_BLEND_MODE, pbm_pkg::MODE_NORMAL);
    add_cfg(pbm_pkg::REG_OPACITY, 0);
    add_pixel(pbm_pkg::pixel_in_t'(48'h123456_ffffff), 1'b1,
              pbm_pkg::pixel_out_t'(24'h123456));
    // opacity above full range behaves as full
    add_cfg(pbm_pkg::REG_OPACITY, 511);
    add_pixel(pbm_pkg::pixel_in_t'(48'h000000_aabbcc), 1'b1,
              pbm_pkg::pixel_out_t'(24'haabbcc));
    add_cfg(pbm_pkg::REG_BLEND_MODE, pbm_pkg::MODE_DIFFERENCE);
    add_cfg(pbm_pkg::REG_OPACITY, 257);
    add_pixel(pbm_pkg::pixel_in_t'(48'hffffff_ff00ff), 1'b1,
              pbm_pkg::pixel_out_t'(24'h00ff00));
    add_cfg(pbm_pkg::REG_BLEND_MODE, pbm_pkg::MODE_NORMAL);
    add_cfg(pbm_pkg::REG_OPACITY, 128);
    add_pixel(pbm_pkg::pixel_in_t'(48'h00ff10_ff0020), 1'b0, '0);
    add_pixel(pbm_pkg::pixel_in_t'(48'h80807f_7f8080), 1'b0, '0);
    add_cfg(pbm_pkg::REG_BLEND_MODE, pbm_pkg::MODE_OVERLAY);
    add_cfg(pbm_pkg::REG_OPACITY, 1);
    add_pixel(pbm_pkg::pixel_in_t'(48'hff00ff_00ff00), 1'b0, '0);
    add_pixel(pbm_pkg::pixel_in_t'(48'h7f80ff_807f01), 1'b0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG)
        write_reg(script[i].reg_sel, script[i].value);
      else
        send_pixel(script[i].pix, script[i].typed, script[i].want, 0);
    end

    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      op_val = (ph < 7) ? op_corner[ph]
             : ($urandom_range(9) == 0) ? $urandom_range(511, 257) : $urandom_range(256);
      write_reg(pbm_pkg::REG_BLEND_MODE, (ph < 8) ? ph : $urandom_range(7));
      write_reg(pbm_pkg::REG_OPACITY, op_val);
      for (int unsigned n = 0; n < PHASE_PIXELS; n++)
        send_pixel(pick_pixel(), 1'b0, '0, idle_pct[ph % 3]);
    end
    start <= 1'b0;

    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (expected_pixels.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", expected_pixels.size());
    end
    $display("blended %0d pixels (%0d results) over %0d register writes,", pixels_sent,
             pixels_seen, settings_used);
    $display("all eight mode codes and opacity 0..511, with and without request gaps");
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
